// ----- rtl/bus_packet_field_decoder_core_macros.svh -----
// Assertion macros for the bus packet field decoder.
// Used by the top level only; no other dependencies.
`ifndef BUS_PACKET_FIELD_DECODER_CORE_MACROS_SVH
`define BUS_PACKET_FIELD_DECODER_CORE_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define BPFD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define BPFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bpfd_pkg.sv -----
// Shared types, codes and widths for the bus packet field decoder.
// No dependencies; used by bpfd_parser and bus_packet_field_decoder_core.
`timescale 1ns / 1ps

package bpfd_pkg;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    localparam logic [3:0] TYPE_CMD_SEND   = 4'h6;
    localparam logic [3:0] TYPE_RSP_STATUS = 4'h8;
    localparam logic [3:0] TYPE_RSP_SEND   = 4'hB;
    localparam logic [3:0] TYPE_UNKNOWN_LO = 4'hE;

    localparam logic [2:0] ROLE_HEADER   = 3'd0;
    localparam logic [2:0] ROLE_LEN_HI   = 3'd1;
    localparam logic [2:0] ROLE_LEN_LO   = 3'd2;
    localparam logic [2:0] ROLE_TXCODE   = 3'd3;
    localparam logic [2:0] ROLE_DEVSTAT  = 3'd4;
    localparam logic [2:0] ROLE_PAYLOAD  = 3'd5;
    localparam logic [2:0] ROLE_CHECKSUM = 3'd6;

    localparam logic [7:0] TXCODE_BLOCK = 8'h01;

    typedef struct packed {
        logic        valid;
        logic [2:0]  field_role;
        logic [3:0]  device_number;
        logic [3:0]  packet_type;
        logic [7:0]  byte_value;
        logic [15:0] message_length;
        logic        block_mode;
        logic        unknown_type;
        logic        end_of_packet;
    } bpfd_result_t;

    function automatic logic has_length(input logic [3:0] ptype);
        return (ptype == TYPE_CMD_SEND) || (ptype == TYPE_RSP_SEND) ||
               (ptype == TYPE_RSP_STATUS);
    endfunction

endpackage

// ----- rtl/bus_packet_field_decoder_core.sv -----
// Top level of the bus packet field decoder: input register, parser, result register.
// Depends on bpfd_pkg, bpfd_parser and bus_packet_field_decoder_core_macros.svh.
`timescale 1ns / 1ps
`include "bus_packet_field_decoder_core_macros.svh"

// Labels each received bus byte with its role in a packet (header, length, transmit
// code, device status, payload, checksum) and marks the last byte with m_tlast. An
// idle request (s_tuser set) produces no result and rearms header detection; bytes
// after a packet's end produce nothing until an idle request. One request is taken
// every clock cycle unless backpressure stalls the input; a result passes through
// the input register and then the result register, with the phase update done
// while its request is in the input register. Backpressure on m_tready stalls the
// input side only once both registers are full.
module bus_packet_field_decoder_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bpfd_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic [bpfd_pkg::S_TUSER_W-1:0]  s_tuser,   // [0] command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bpfd_pkg::M_TDATA_W-1:0]  m_tdata,   // [3:0] device_number,
                                                       // [7:4] packet_type,
                                                       // [15:8] byte_value,
                                                       // [31:16] message_length,
                                                       // [32] block_mode,
                                                       // [33] unknown_type, rest zero
    output logic [bpfd_pkg::M_TUSER_W-1:0]  m_tuser,   // [2:0] field_role
    output logic                            m_tlast
);
    import bpfd_pkg::*;

    logic         in_valid_reg;
    logic         in_cmd_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg, out_valid_next;
    bpfd_result_t out_reg;
    bpfd_result_t res;
    logic         advance;
    logic         out_load;

    bpfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .command   (in_cmd_reg),
        .data_byte (in_byte_reg),
        .result    (res)
    );

    assign advance  = in_valid_reg && (!res.valid || !out_valid_reg || m_tready);
    assign out_load = advance && res.valid;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg  <= s_tuser[0];
            in_byte_reg <= s_tdata[7:0];
        end
        if (out_load) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.field_role;
    assign m_tlast  = out_reg.end_of_packet;
    assign m_tdata  = {6'd0, out_reg.unknown_type, out_reg.block_mode,
                       out_reg.message_length, out_reg.byte_value,
                       out_reg.packet_type, out_reg.device_number};

    `BPFD_ASSERT_NOW(a_hdr_clean, aclk, aresetn, (m_tvalid && (m_tuser == ROLE_HEADER)), ((m_tdata[31:16] == 16'd0) && !m_tdata[32]), "header result carries length or block mode")
    `BPFD_ASSERT_NOW(a_last_role, aclk, aresetn, (m_tvalid && m_tlast), ((m_tuser == ROLE_HEADER) || (m_tuser == ROLE_CHECKSUM)), "packet end on a role that cannot end a packet")
    `BPFD_ASSERT_NOW(a_block_role, aclk, aresetn, (m_tvalid && m_tdata[32]), (m_tuser == ROLE_TXCODE), "block mode outside the transmit code byte")
    `BPFD_ASSERT_NEXT(a_in_hold, aclk, aresetn, (in_valid_reg && !advance), (in_valid_reg && $stable(in_byte_reg) && $stable(in_cmd_reg)), "stalled input register changed")

endmodule

// ----- rtl/bpfd_parser.sv -----
// Packet phase tracker and byte labeler for the bus packet field decoder.
// Depends on bpfd_pkg; state advances once per stepped request.
`timescale 1ns / 1ps

module bpfd_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic                  command,
    input  logic [7:0]            data_byte,
    output bpfd_pkg::bpfd_result_t result
);
    import bpfd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_CHECKSUM,
        PH_TXCODE,
        PH_DEVSTATUS,
        PH_WAIT_IDLE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] remain_reg, remain_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [3:0]  device_reg, device_next;
    logic [3:0]  ptype_reg, ptype_next;
    logic [15:0] length_reg, length_next;
    logic [2:0]  role;
    logic        block;
    logic        eop;
    logic        emit;
    logic [15:0] length_asm;

    assign length_asm = {len_hi_reg, data_byte};

    always_comb begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        len_hi_next = len_hi_reg;
        device_next = device_reg;
        ptype_next  = ptype_reg;
        length_next = length_reg;
        role        = ROLE_HEADER;
        block       = 1'b0;
        eop         = 1'b0;
        emit        = 1'b0;
        if (command) begin
            phase_next = PH_HEADER;
        end else begin
            emit = 1'b1;
            unique case (phase_reg)
                PH_HEADER: begin
                    device_next = data_byte[3:0];
                    ptype_next  = data_byte[7:4];
                    length_next = '0;
                    len_hi_next = '0;
                    remain_next = '0;
                    role        = ROLE_HEADER;
                    if (has_length(data_byte[7:4])) begin
                        phase_next = PH_LEN_HI;
                    end else begin
                        eop        = 1'b1;
                        phase_next = PH_WAIT_IDLE;
                    end
                end
                PH_LEN_HI: begin
                    len_hi_next = data_byte;
                    role        = ROLE_LEN_HI;
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    length_next = length_asm;
                    role        = ROLE_LEN_LO;
                    if (ptype_reg == TYPE_RSP_STATUS) begin
                        phase_next = PH_TXCODE;
                    end else begin
                        remain_next = length_asm;
                        phase_next  = (length_asm != '0) ? PH_PAYLOAD : PH_CHECKSUM;
                    end
                end
                PH_PAYLOAD: begin
                    role        = ROLE_PAYLOAD;
                    remain_next = remain_reg - 16'd1;
                    if (remain_next == '0) begin
                        phase_next = PH_CHECKSUM;
                    end
                end
                PH_TXCODE: begin
                    role       = ROLE_TXCODE;
                    block      = (data_byte == TXCODE_BLOCK);
                    phase_next = PH_DEVSTATUS;
                end
                PH_DEVSTATUS: begin
                    role       = ROLE_DEVSTAT;
                    phase_next = PH_CHECKSUM;
                end
                PH_CHECKSUM: begin
                    role       = ROLE_CHECKSUM;
                    eop        = 1'b1;
                    phase_next = PH_WAIT_IDLE;
                end
                PH_WAIT_IDLE: begin
                    emit = 1'b0;
                end
                default: begin
                    emit       = 1'b0;
                    phase_next = PH_WAIT_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        result.valid          = emit;
        result.field_role     = role;
        result.device_number  = device_next;
        result.packet_type    = ptype_next;
        result.byte_value     = data_byte;
        result.message_length = length_next;
        result.block_mode     = block;
        result.unknown_type   = (ptype_next >= TYPE_UNKNOWN_LO);
        result.end_of_packet  = eop;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            remain_reg <= '0;
            len_hi_reg <= '0;
            device_reg <= '0;
            ptype_reg  <= '0;
            length_reg <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            len_hi_reg <= len_hi_next;
            device_reg <= device_next;
            ptype_reg  <= ptype_next;
            length_reg <= length_next;
        end
    end

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for bus_packet_field_decoder_core: labels on bus bytes and idle requests.
// A directed table, then random packets; labels checked by a built-in decoder or typed rows.
// Depends on bpfd_pkg and the bus_packet_field_decoder_core RTL.
`timescale 1ns / 1ps

module testbench;
    import bpfd_pkg::*;

    localparam int TARGET_REQUESTS = 1650;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int CALM_FROM       = 800;
    localparam int CALM_TO         = 1400;
    localparam int DRAIN_CYCLES    = 10;

    typedef enum logic [3:0] {
        PH_AWAIT_HEADER, PH_LEN_HIGH, PH_LEN_LOW, PH_PAYLOAD,
        PH_CHECKSUM, PH_TXCODE, PH_DEVSTATUS, PH_WAIT_IDLE
    } frame_phase_t;

    typedef struct packed {
        logic [2:0]  role;
        logic [3:0]  device;
        logic [3:0]  ptype;
        logic [7:0]  value;
        logic [15:0] length;
        logic        block;
        logic        unknown;
        logic        last;
    } byte_label_t;

    typedef struct packed {
        logic        idle;
        logic [7:0]  value;
        logic        typed;
        byte_label_t label;
    } bus_request_t;

    localparam int DIRECTED_ROWS = 27;

    // typed labels only where they are plain: unknown headers and the block-mode transmit code
    localparam bus_request_t DIRECTED [DIRECTED_ROWS] = '{
        '{1'b0, 8'hFF, 1'b1, '{ROLE_HEADER, 4'hF, 4'hF, 8'hFF, 16'h0000, 1'b0, 1'b1, 1'b1}},
        '{1'b0, 8'h55, 1'b0, '0},
        '{1'b1, 8'h00, 1'b0, '0},
        '{1'b0, 8'h6A, 1'b0, '0},
        '{1'b0, 8'h00, 1'b0, '0},
        '{1'b0, 8'h02, 1'b0, '0},
        '{1'b0, 8'hFF, 1'b0, '0},
        '{1'b0, 8'h00, 1'b0, '0},
        '{1'b0, 8'h12, 1'b0, '0},
        '{1'b1, 8'hFF, 1'b0, '0},
        '{1'b0, 8'hB3, 1'b0, '0},
        '{1'b0, 8'h00, 1'b0, '0},
        '{1'b0, 8'h00, 1'b0, '0},
        '{1'b0, 8'hAB, 1'b0, '0},
        '{1'b1, 8'h00, 1'b0, '0},
        '{1'b0, 8'h81, 1'b0, '0},
        '{1'b0, 8'hFF, 1'b0, '0},
        '{1'b0, 8'hFF, 1'b0, '0},
        '{1'b0, 8'h01, 1'b1, '{ROLE_TXCODE, 4'h1, 4'h8, 8'h01, 16'hFFFF, 1'b1, 1'b0, 1'b0}},
        '{1'b0, 8'h7E, 1'b0, '0},
        '{1'b0, 8'h80, 1'b0, '0},
        '{1'b1, 8'h00, 1'b0, '0},
        '{1'b0, 8'h62, 1'b0, '0},
        '{1'b0, 8'h00, 1'b0, '0},
        '{1'b1, 8'h00, 1'b0, '0},
        '{1'b0, 8'hE5, 1'b1, '{ROLE_HEADER, 4'h5, 4'hE, 8'hE5, 16'h0000, 1'b0, 1'b1, 1'b1}},
        '{1'b0, 8'hD0, 1'b0, '0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] data_byte
    logic [0:0]  s_tuser = '0;   // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // [3:0] device, [7:4] type, [15:8] byte, [31:16] length,
                                 // [32] block_mode, [33] unknown_type, rest zero
    logic [2:0]  m_tuser;        // [2:0] field_role
    logic        m_tlast;

    bus_request_t byte_requests [$];
    byte_label_t  pending_labels [$];
    bus_request_t in_flight = '0;
    int           total_requests = 0;
    int           accepted_requests = 0;
    int           failures = 0;
    int           cycle_count = 0;

    frame_phase_t phase = PH_AWAIT_HEADER;
    logic [15:0]  payload_left = '0;
    logic [7:0]   length_high = '0;
    logic [3:0]   cur_device = '0;
    logic [3:0]   cur_type = '0;
    logic [15:0]  cur_length = '0;

    bus_packet_field_decoder_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic calm_window(input int cyc);
        return cyc >= CALM_FROM && cyc < CALM_TO;
    endfunction

    task automatic add_request(input logic idle, input logic [7:0] value);
        bus_request_t rq;
        rq = '0;
        rq.idle = idle;
        rq.value = value;
        byte_requests.push_back(rq);
    endtask

    task automatic label_byte(input bus_request_t rq, output logic produced,
                              output byte_label_t lbl);
        lbl = '0;
        produced = 1'b0;
        if (rq.idle) begin
            phase = PH_AWAIT_HEADER;
            return;
        end
        produced = 1'b1;
        case (phase)
            PH_AWAIT_HEADER: begin
                cur_device = rq.value[3:0];
                cur_type = rq.value[7:4];
                cur_length = '0;
                length_high = '0;
                payload_left = '0;
                lbl.role = ROLE_HEADER;
                if (cur_type == TYPE_CMD_SEND || cur_type == TYPE_RSP_SEND ||
                    cur_type == TYPE_RSP_STATUS) begin
                    phase = PH_LEN_HIGH;
                end else begin
                    lbl.last = 1'b1;
                    phase = PH_WAIT_IDLE;
                end
            end
            PH_LEN_HIGH: begin
                length_high = rq.value;
                lbl.role = ROLE_LEN_HI;
                phase = PH_LEN_LOW;
            end
            PH_LEN_LOW: begin
                cur_length = {length_high, rq.value};
                lbl.role = ROLE_LEN_LO;
                if (cur_type == TYPE_RSP_STATUS) begin
                    phase = PH_TXCODE;
                end else begin
                    payload_left = cur_length;
                    phase = (payload_left != 0) ? PH_PAYLOAD : PH_CHECKSUM;
                end
            end
            PH_PAYLOAD: begin
                lbl.role = ROLE_PAYLOAD;
                payload_left = payload_left - 16'd1;
                if (payload_left == 0) phase = PH_CHECKSUM;
            end
            PH_TXCODE: begin
                lbl.role = ROLE_TXCODE;
                lbl.block = (rq.value == TXCODE_BLOCK);
                phase = PH_DEVSTATUS;
            end
            PH_DEVSTATUS: begin
                lbl.role = ROLE_DEVSTAT;
                phase = PH_CHECKSUM;
            end
            PH_CHECKSUM: begin
                lbl.role = ROLE_CHECKSUM;
                lbl.last = 1'b1;
                phase = PH_WAIT_IDLE;
            end
            default: begin
                phase = PH_WAIT_IDLE;
                produced = 1'b0;
            end
        endcase
        lbl.device = cur_device;
        lbl.ptype = cur_type;
        lbl.value = rq.value;
        lbl.length = cur_length;
        lbl.unknown = (cur_type >= TYPE_UNKNOWN_LO);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            failures++;
        end
    endtask

    task automatic build_random_packets();
        logic [7:0]  pkt [$];
        logic [3:0]  ptype;
        logic [15:0] len;
        int          pick;
        int          cut;
        while (byte_requests.size() < TARGET_REQUESTS) begin
            pkt.delete();
            // leave out the idle now and then so the next bytes land in the drop phase
            if ($urandom_range(99) < 90) add_request(1'b1, 8'($urandom()));
            pick = $urandom_range(99);
            if (pick < 35) begin
                ptype = $urandom_range(1) ? TYPE_CMD_SEND : TYPE_RSP_SEND;
                cut = $urandom_range(99);
                if (cut < 80) len = 16'($urandom_range(8));
                else if (cut < 95) len = 16'($urandom_range(40, 9));
                else len = 16'($urandom_range(270, 250));
                pkt.push_back({ptype, 4'($urandom())});
                pkt.push_back(len[15:8]);
                pkt.push_back(len[7:0]);
                repeat (len) pkt.push_back(8'($urandom()));
                pkt.push_back(8'($urandom()));
            end else if (pick < 60) begin
                pkt.push_back({TYPE_RSP_STATUS, 4'($urandom())});
                pkt.push_back(8'($urandom()));
                pkt.push_back(8'($urandom()));
                pkt.push_back($urandom_range(1) ? TXCODE_BLOCK : 8'($urandom()));
                pkt.push_back(8'($urandom()));
                pkt.push_back(8'($urandom()));
            end else if (pick < 85) begin
                pkt.push_back(8'($urandom()));
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    if ($urandom_range(99) < 20) add_request(1'b1, 8'($urandom()));
                    else pkt.push_back(8'($urandom()));
                end
            end
            // truncate some packets; the next idle abandons them
            if (pkt.size() > 1 && $urandom_range(99) < 12) begin
                cut = $urandom_range(pkt.size() - 1, 1);
                while (pkt.size() > cut) void'(pkt.pop_back());
            end
            if ($urandom_range(99) < 20) begin
                repeat ($urandom_range(3, 1)) pkt.push_back(8'($urandom()));
            end
            foreach (pkt[i]) add_request(1'b0, pkt[i]);
        end
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("bus_packet_field_decoder_core verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin : drive_requests
        bus_request_t rq;
        m_tready <= calm_window(cycle_count) || ($urandom_range(99) >= 22);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (byte_requests.size() != 0 &&
                (calm_window(cycle_count) || $urandom_range(99) >= 22)) begin
                rq = byte_requests.pop_front();
                in_flight <= rq;
                s_tdata <= rq.value;
                s_tuser <= rq.idle;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : track_labels
        byte_label_t want;
        byte_label_t predicted;
        logic        produced;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_labels.size() == 0) begin
                $display("%0t: label with none expected, actual role %0d byte 0x%0h",
                         $time, m_tuser, m_tdata[15:8]);
                failures++;
            end else begin
                want = pending_labels.pop_front();
                compare_field("field_role", want.role, m_tuser);
                compare_field("device_number", want.device, m_tdata[3:0]);
                compare_field("packet_type", want.ptype, m_tdata[7:4]);
                compare_field("byte_value", want.value, m_tdata[15:8]);
                compare_field("message_length", want.length, m_tdata[31:16]);
                compare_field("block_mode", want.block, m_tdata[32]);
                compare_field("unknown_type", want.unknown, m_tdata[33]);
                compare_field("tdata padding", 0, m_tdata[39:34]);
                compare_field("end_of_packet", want.last, m_tlast);
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            label_byte(in_flight, produced, predicted);
            if (produced) pending_labels.push_back(in_flight.typed ? in_flight.label : predicted);
            accepted_requests++;
        end
    end

    initial begin
        foreach (DIRECTED[i]) byte_requests.push_back(DIRECTED[i]);
        build_random_packets();
        total_requests = byte_requests.size();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        while (accepted_requests != total_requests) @(posedge aclk);
        while (pending_labels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("bus_packet_field_decoder_core verification clean");
        end else begin
            $display("bus_packet_field_decoder_core verification failed");
        end
        $finish;
    end

endmodule

// ----- bus_packet_field_decoder_core.f -----
+incdir+rtl
rtl/bpfd_pkg.sv
rtl/bpfd_parser.sv
rtl/bus_packet_field_decoder_core.sv
bench/testbench.sv
